FILE: hdl/pib_pkg.sv
// Shared types, constants and helpers for the particle integrate and bounce core.
package pib_pkg;

	localparam int QW = 24;
	localparam int RW = 23;
	localparam int NREGS = 8;
	localparam int IW = 3;
	localparam int SQW = 25;
	localparam int SQ_STEPS = SQW;
	localparam int DIVW = 24;
	localparam int NUMW = 48;
	localparam int DIV_STEPS = 26;

	localparam logic signed [QW-1:0] Q_MAX = 24'sh7FFFFF;
	localparam logic signed [QW-1:0] Q_MIN = -24'sh800000;
	localparam logic [16:0] BOUNCE_K = 17'd45875;
	localparam logic [16:0] DAMP_K = 17'd64881;

	typedef enum logic [IW-1:0] {
		REG_GRAVITY = 3'd0,
		REG_WALL_LEFT = 3'd1,
		REG_WALL_RIGHT = 3'd2,
		REG_WALL_TOP = 3'd3,
		REG_WALL_BOTTOM = 3'd4,
		REG_OBST_X = 3'd5,
		REG_OBST_Y = 3'd6,
		REG_CONTACT_R = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [RW-1:0] gravity;
		logic [RW-1:0] wall_left;
		logic [RW-1:0] wall_right;
		logic [RW-1:0] wall_top;
		logic [RW-1:0] wall_bottom;
		logic [RW-1:0] obst_x;
		logic [RW-1:0] obst_y;
		logic [RW-1:0] contact_r;
	} cfg_t;

	typedef struct packed {
		logic signed [QW-1:0] pos_x;
		logic signed [QW-1:0] pos_y;
		logic signed [QW-1:0] vel_x;
		logic signed [QW-1:0] vel_y;
	} particle_t;

	// Saturate a wide signed value into Q12.12.
	function automatic logic signed [QW-1:0] sat24(input logic signed [47:0] v);
		logic signed [QW-1:0] r;
		if (v > 48'(signed'(Q_MAX))) r = Q_MAX;
		else if (v < 48'(signed'(Q_MIN))) r = Q_MIN;
		else r = v[QW-1:0];
		return r;
	endfunction

	// Scale by a Q1.16 factor, round half away from zero, optionally negate, saturate.
	function automatic logic signed [QW-1:0] mul_q16(input logic signed [QW-1:0] v,
			input logic [16:0] k, input logic neg);
		logic [QW:0] mag;
		logic [41:0] m;
		logic signed [47:0] r;
		mag = v[QW-1] ? (QW+1)'(-$signed({v[QW-1], v})) : {1'b0, v};
		m = 42'(mag) * 42'(k);
		r = 48'((m + 42'd32768) >> 16);
		if (v[QW-1] ^ neg) r = -r;
		return sat24(r);
	endfunction

endpackage

FILE: hdl/pib_if.sv
// Valid/ready channel carrying one particle item.
interface pib_if;
	import pib_pkg::*;
	logic valid;
	logic ready;
	particle_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: hdl/pib_regs.sv
// Configuration register file.
module pib_regs (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [pib_pkg::IW-1:0] cfg_index,
	input logic [pib_pkg::RW-1:0] cfg_data,
	output pib_pkg::cfg_t cfg
);
	import pib_pkg::*;

	// Hold register values, write one at a time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.gravity <= 23'd402;
			cfg.wall_left <= 23'd1011712;
			cfg.wall_right <= 23'd2142208;
			cfg.wall_top <= 23'd110592;
			cfg.wall_bottom <= 23'd1937408;
			cfg.obst_x <= 23'd819200;
			cfg.obst_y <= 23'd819200;
			cfg.contact_r <= 23'd28672;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_GRAVITY: cfg.gravity <= cfg_data;
				REG_WALL_LEFT: cfg.wall_left <= cfg_data;
				REG_WALL_RIGHT: cfg.wall_right <= cfg_data;
				REG_WALL_TOP: cfg.wall_top <= cfg_data;
				REG_WALL_BOTTOM: cfg.wall_bottom <= cfg_data;
				REG_OBST_X: cfg.obst_x <= cfg_data;
				REG_OBST_Y: cfg.obst_y <= cfg_data;
				REG_CONTACT_R: cfg.contact_r <= cfg_data;
				default: ;
			endcase
		end
	end
endmodule

FILE: hdl/pib_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module pib_sqrt (
	input logic clk,
	input logic en,
	input logic [2*pib_pkg::SQW-1:0] rad,
	output logic [pib_pkg::SQW-1:0] root
);
	import pib_pkg::*;

	logic [2*SQW-1:0] rem_s [SQ_STEPS+1];
	logic [SQW-1:0] res_s [SQ_STEPS+1];

	assign rem_s[0] = rad;
	assign res_s[0] = '0;

	// Decide one root bit per stage, from the top.
	for (genvar i = 0; i < SQ_STEPS; i++) begin : g_st
		localparam int B = SQW - 1 - i;
		logic [2*SQW+1:0] trial;
		logic [2*SQW+1:0] cur;
		always_comb begin
			cur = (2*SQW+2)'(res_s[i]) << (B + 1);
			trial = cur + ((2*SQW+2)'(1) << (2*B));
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if ((2*SQW+2)'(rem_s[i]) >= trial) begin
					rem_s[i+1] <= rem_s[i] - (2*SQW)'(trial);
					res_s[i+1] <= res_s[i] | (SQW'(1) << B);
				end else begin
					rem_s[i+1] <= rem_s[i];
					res_s[i+1] <= res_s[i];
				end
			end
		end
	end

	assign root = res_s[SQ_STEPS];
endmodule

FILE: hdl/pib_div.sv
// Pipelined restoring divider for the rounded push quotient, one bit per stage.
module pib_div (
	input logic clk,
	input logic en,
	input logic [pib_pkg::NUMW+1:0] num,
	input logic [pib_pkg::DIVW+1:0] den,
	output logic [pib_pkg::DIV_STEPS-1:0] quo
);
	import pib_pkg::*;

	localparam int RMW = NUMW + 2;

	logic [RMW-1:0] rem_s [DIV_STEPS+1];
	logic [DIVW+1:0] den_s [DIV_STEPS+1];
	logic [DIV_STEPS-1:0] q_s [DIV_STEPS+1];

	assign rem_s[0] = num;
	assign den_s[0] = den;
	assign q_s[0] = '0;

	// Resolve one quotient bit per stage, from the top.
	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_st
		localparam int B = DIV_STEPS - 1 - i;
		logic [RMW+DIV_STEPS-1:0] sh;
		assign sh = (RMW+DIV_STEPS)'(den_s[i]) << B;
		always_ff @(posedge clk) begin
			if (en) begin
				den_s[i+1] <= den_s[i];
				if ((RMW+DIV_STEPS)'(rem_s[i]) >= sh) begin
					rem_s[i+1] <= rem_s[i] - RMW'(sh);
					q_s[i+1] <= q_s[i] | (DIV_STEPS'(1) << B);
				end else begin
					rem_s[i+1] <= rem_s[i];
					q_s[i+1] <= q_s[i];
				end
			end
		end
	end

	assign quo = q_s[DIV_STEPS];
endmodule

FILE: hdl/particle_integrate_bounce_core.sv
// Top level of the particle integrate and bounce core.
// One particle item can enter per clock while the output register is empty or
// taken; its result passes through five front stages, a 25-stage square root,
// one operand stage, a 26-stage divider, a push stage and the output register.
// The whole path is one pipeline that advances when the output register is
// empty or taken, so a waiting result that is not taken stalls every item in
// flight, and sustained throughput is one item per cycle while results are
// taken. The user must write registers through the cfg port only while the
// core is idle; the core itself does not enforce this.
module particle_integrate_bounce_core (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [pib_pkg::IW-1:0] cfg_index,
	input logic [pib_pkg::RW-1:0] cfg_data,
	pib_if.sink in_ch,
	pib_if.source out_ch
);
	import pib_pkg::*;

	localparam int LAT_SQ = SQ_STEPS;
	localparam int LAT_DV = DIV_STEPS;
	localparam int NV = 5 + LAT_SQ + 1 + LAT_DV + 2;

	cfg_t cfg;
	logic en;
	logic [NV-1:0] vld_q;

	pib_regs u_regs (.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data, .cfg);

	// Advance whole pipeline unless the last item waits.
	assign en = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[NV-2:0], in_ch.valid};
	end
	assign out_ch.valid = vld_q[NV-1];

	// Stage 1: gravity and move.
	logic signed [QW-1:0] x_s1, y_s1, vx_s1, vy_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			logic signed [QW-1:0] vy;
			vy = sat24(48'(in_ch.data.vel_y) + 48'(signed'({1'b0, cfg.gravity})));
			vy_s1 <= vy;
			vx_s1 <= in_ch.data.vel_x;
			x_s1 <= sat24(48'(in_ch.data.pos_x) + 48'(in_ch.data.vel_x));
			y_s1 <= sat24(48'(in_ch.data.pos_y) + 48'(vy));
		end
	end

	// Stage 2: wall clamps with hit flags.
	logic signed [QW-1:0] x_s2, y_s2, vx_s2, vy_s2;
	logic hx_s2, hb_s2, ht_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			logic signed [QW-1:0] wl, wr, wt, wb, yb;
			logic hb;
			wl = signed'({1'b0, cfg.wall_left});
			wr = signed'({1'b0, cfg.wall_right});
			wt = signed'({1'b0, cfg.wall_top});
			wb = signed'({1'b0, cfg.wall_bottom});
			if (x_s1 < wl) begin x_s2 <= wl; hx_s2 <= 1'b1; end
			else if (x_s1 > wr) begin x_s2 <= wr; hx_s2 <= 1'b1; end
			else begin x_s2 <= x_s1; hx_s2 <= 1'b0; end
			hb = y_s1 > wb;
			yb = hb ? wb : y_s1;
			hb_s2 <= hb;
			ht_s2 <= yb < wt;
			y_s2 <= (yb < wt) ? wt : yb;
			vx_s2 <= vx_s1;
			vy_s2 <= vy_s1;
		end
	end

	// Stage 3: first bounces and offsets from the obstacle.
	logic signed [QW-1:0] x_s3, y_s3, vx_s3, vy_s3;
	logic hy2_s3;
	logic signed [QW:0] dx_s3, dy_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			vx_s3 <= hx_s2 ? mul_q16(vx_s2, BOUNCE_K, 1'b1) : vx_s2;
			vy_s3 <= (hb_s2 || ht_s2) ? mul_q16(vy_s2, BOUNCE_K, 1'b1) : vy_s2;
			hy2_s3 <= hb_s2 && ht_s2;
			x_s3 <= x_s2;
			y_s3 <= y_s2;
			dx_s3 <= (QW+1)'(x_s2) - (QW+1)'(signed'({1'b0, cfg.obst_x}));
			dy_s3 <= (QW+1)'(y_s2) - (QW+1)'(signed'({1'b0, cfg.obst_y}));
		end
	end

	// Stage 4: second top bounce and squares.
	logic signed [QW-1:0] x_s4, y_s4, vx_s4, vy_s4;
	logic signed [QW:0] dx_s4, dy_s4;
	logic [2*QW+1:0] dx2_s4, dy2_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			logic [QW:0] ax, ay;
			ax = dx_s3[QW] ? (QW+1)'(-dx_s3) : dx_s3;
			ay = dy_s3[QW] ? (QW+1)'(-dy_s3) : dy_s3;
			dx2_s4 <= (2*QW+2)'(ax) * (2*QW+2)'(ax);
			dy2_s4 <= (2*QW+2)'(ay) * (2*QW+2)'(ay);
			vy_s4 <= hy2_s3 ? mul_q16(vy_s3, BOUNCE_K, 1'b1) : vy_s3;
			vx_s4 <= vx_s3;
			x_s4 <= x_s3;
			y_s4 <= y_s3;
			dx_s4 <= dx_s3;
			dy_s4 <= dy_s3;
		end
	end

	// Stage 5: squared distance and contact test.
	logic signed [QW-1:0] x_s5, y_s5, vx_s5, vy_s5;
	logic signed [QW:0] dx_s5, dy_s5;
	logic [2*SQW-1:0] d2_s5;
	logic hit_s5;
	always_ff @(posedge clk) begin
		if (en) begin
			logic [2*SQW-1:0] d2;
			logic [2*RW-1:0] r2;
			d2 = (2*SQW)'(dx2_s4) + (2*SQW)'(dy2_s4);
			r2 = (2*RW)'(cfg.contact_r) * (2*RW)'(cfg.contact_r);
			d2_s5 <= d2;
			hit_s5 <= d2 < (2*SQW)'(r2);
			x_s5 <= x_s4; y_s5 <= y_s4; vx_s5 <= vx_s4; vy_s5 <= vy_s4;
			dx_s5 <= dx_s4; dy_s5 <= dy_s4;
		end
	end

	// Delay line beside the square root.
	typedef struct packed {
		particle_t p;
		logic signed [QW:0] dx;
		logic signed [QW:0] dy;
		logic hit;
		logic nz;
	} side_t;
	side_t sq_d [LAT_SQ+1];
	assign sq_d[0] = '{p: '{x_s5, y_s5, vx_s5, vy_s5}, dx: dx_s5, dy: dy_s5,
		hit: hit_s5, nz: d2_s5 != '0};
	for (genvar i = 0; i < LAT_SQ; i++) begin : g_sqd
		always_ff @(posedge clk) if (en) sq_d[i+1] <= sq_d[i];
	end

	logic [SQW-1:0] dlen;
	pib_sqrt u_sqrt (.clk, .en, .rad(d2_s5), .root(dlen));

	// Stage 6: overlap and divider operands.
	side_t s6;
	logic [NUMW+1:0] numx_s6, numy_s6;
	logic [DIVW+1:0] den_s6;
	always_ff @(posedge clk) begin
		if (en) begin
			logic [RW:0] ov;
			logic [QW:0] ax, ay;
			ov = (RW+1)'(cfg.contact_r) - (RW+1)'(dlen);
			ax = sq_d[LAT_SQ].dx[QW] ? (QW+1)'(-sq_d[LAT_SQ].dx) : sq_d[LAT_SQ].dx;
			ay = sq_d[LAT_SQ].dy[QW] ? (QW+1)'(-sq_d[LAT_SQ].dy) : sq_d[LAT_SQ].dy;
			numx_s6 <= ((NUMW+2)'(ov) * (NUMW+2)'(ax) << 1) + (NUMW+2)'(dlen);
			numy_s6 <= ((NUMW+2)'(ov) * (NUMW+2)'(ay) << 1) + (NUMW+2)'(dlen);
			den_s6 <= (DIVW+2)'(dlen) << 1;
			s6 <= sq_d[LAT_SQ];
		end
	end

	side_t dv_d [LAT_DV+1];
	assign dv_d[0] = s6;
	for (genvar i = 0; i < LAT_DV; i++) begin : g_dvd
		always_ff @(posedge clk) if (en) dv_d[i+1] <= dv_d[i];
	end

	logic [DIV_STEPS-1:0] qx, qy;
	pib_div u_divx (.clk, .en, .num(numx_s6), .den(den_s6), .quo(qx));
	pib_div u_divy (.clk, .en, .num(numy_s6), .den(den_s6), .quo(qy));

	// Stage 7: push out and contact bounce.
	particle_t s7;
	always_ff @(posedge clk) begin
		if (en) begin
			side_t d;
			particle_t nxt;
			logic signed [47:0] px, py;
			d = dv_d[LAT_DV];
			px = d.dx[QW] ? -48'(qx) : 48'(qx);
			py = d.dy[QW] ? -48'(qy) : 48'(qy);
			nxt = d.p;
			if (d.hit) begin
				if (d.nz) begin
					nxt.pos_x = sat24(48'(d.p.pos_x) + px);
					nxt.pos_y = sat24(48'(d.p.pos_y) + py);
				end
				nxt.vel_x = mul_q16(d.p.vel_x, BOUNCE_K, 1'b1);
				nxt.vel_y = mul_q16(d.p.vel_y, BOUNCE_K, 1'b1);
			end
			s7 <= nxt;
		end
	end

	// Stage 8: damping into the output register.
	always_ff @(posedge clk) begin
		if (en) begin
			out_ch.data.pos_x <= s7.pos_x;
			out_ch.data.pos_y <= s7.pos_y;
			out_ch.data.vel_x <= mul_q16(s7.vel_x, DAMP_K, 1'b0);
			out_ch.data.vel_y <= mul_q16(s7.vel_y, DAMP_K, 1'b0);
		end
	end
endmodule
